// File: rtl/enlm_pkg.sv
// Shared widths and the sideband record of the edge normal, length and midpoint block.
package enlm_pkg;

	localparam int COORD_W = 32;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int SQ_W    = 2 * DIFF_W;
	localparam int ROOT_W  = DIFF_W;
	localparam int REM_W   = ROOT_W + 3;
	localparam int NORM_FRAC = 30;
	localparam int QUO_W   = NORM_FRAC + 1;
	localparam int DREM_W  = ROOT_W + 1;
	localparam int NORM_W  = 32;
	localparam int LEN_W   = 33;

	typedef struct packed {
		logic [DIFF_W-1:0]  ax;
		logic [DIFF_W-1:0]  ay;
		logic               sgn_x;
		logic               sgn_y;
		logic [COORD_W-1:0] mid_x;
		logic [COORD_W-1:0] mid_y;
	} side_t;

endpackage

// File: rtl/enlm_in_if.sv
// Input channel carrying the two end points of one edge.
interface enlm_in_if import enlm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// File: rtl/enlm_out_if.sv
// Output channel carrying the normal, length, midpoint and degenerate flag of one edge.
interface enlm_out_if import enlm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [NORM_W-1:0]  normal_x;
	logic [NORM_W-1:0]  normal_y;
	logic [LEN_W-1:0]   edge_length;
	logic [COORD_W-1:0] mid_x;
	logic [COORD_W-1:0] mid_y;
	logic               degenerate;

	modport source (output valid, normal_x, normal_y, edge_length, mid_x, mid_y, degenerate,
		input ready);
	modport sink (input valid, normal_x, normal_y, edge_length, mid_x, mid_y, degenerate,
		output ready);
endinterface

// File: rtl/edge_normal_length_midpoint_core.sv
// Top level of the edge normal, length and midpoint pipeline.
// The in_edge channel takes one word per edge: the two end points as signed Q16.16.
// The out_edge channel returns one word per edge: the unit normal in signed Q2.30,
// the floored length in unsigned Q17.16, the floored midpoint and a degenerate flag
// that is set, with a zero normal, when both end points coincide.
// One word enters every cycle while the output is not stalled. The word passes through
// the difference, magnitude, square and sum stages, the square-root stages at one root
// bit per stage, the stages of the two normal divisions at one quotient bit per stage,
// and a rounding step into the output register.
// The whole pipeline moves on one enable. When the receiver holds ready low while a
// word waits at the output, every stage holds its contents and in_edge.ready falls, so
// nothing is lost or repeated; while the output register is empty the pipeline keeps
// moving regardless of ready.
// Reset clears all valid bits; the data registers are not reset.
module edge_normal_length_midpoint_core import enlm_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	enlm_in_if.sink     in_edge,
	enlm_out_if.source  out_edge
);

	localparam int NSQ  = ROOT_W;
	localparam int NDIV = QUO_W;

	logic en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [COORD_W-1:0] midx_s1, midy_s1;
	side_t side_s2, side_s3, side_s4;
	logic [SQ_W-1:0] sqx_s3, sqy_s3, n_s4;

	logic [NSQ-1:0]   sqv_s;
	logic [REM_W-1:0] sqrem_s  [NSQ];
	logic [ROOT_W-1:0] root_s  [NSQ];
	logic [SQ_W-1:0]  sqn_s    [NSQ];
	side_t            sqside_s [NSQ];

	logic [NDIV-1:0]   dv_s;
	logic [DREM_W-1:0] remx_s [NDIV];
	logic [DREM_W-1:0] remy_s [NDIV];
	logic [QUO_W-1:0]  qx_s   [NDIV];
	logic [QUO_W-1:0]  qy_s   [NDIV];
	logic [ROOT_W-1:0] len_s  [NDIV];
	side_t             dside_s [NDIV];

	logic vo_q;

	assign en = !vo_q || out_edge.ready;
	assign in_edge.ready = en;
	assign out_edge.valid = vo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			sqv_s <= '0;
			dv_s <= '0;
			vo_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_edge.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			sqv_s <= {sqv_s[NSQ-2:0], v_s4};
			dv_s <= {dv_s[NDIV-2:0], sqv_s[NSQ-1]};
			vo_q <= dv_s[NDIV-1];
		end
	end

	logic [DIFF_W-1:0] sumx, sumy;
	assign sumx = {in_edge.start_x[COORD_W-1], in_edge.start_x}
		+ {in_edge.end_x[COORD_W-1], in_edge.end_x};
	assign sumy = {in_edge.start_y[COORD_W-1], in_edge.start_y}
		+ {in_edge.end_y[COORD_W-1], in_edge.end_y};

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {in_edge.end_y[COORD_W-1], in_edge.end_y}
				- {in_edge.start_y[COORD_W-1], in_edge.start_y};
			dy_s1 <= {in_edge.start_x[COORD_W-1], in_edge.start_x}
				- {in_edge.end_x[COORD_W-1], in_edge.end_x};
			midx_s1 <= sumx[DIFF_W-1:1];
			midy_s1 <= sumy[DIFF_W-1:1];

			side_s2.ax <= dx_s1[DIFF_W-1] ? DIFF_W'(-dx_s1) : DIFF_W'(dx_s1);
			side_s2.ay <= dy_s1[DIFF_W-1] ? DIFF_W'(-dy_s1) : DIFF_W'(dy_s1);
			side_s2.sgn_x <= dx_s1[DIFF_W-1];
			side_s2.sgn_y <= dy_s1[DIFF_W-1];
			side_s2.mid_x <= midx_s1;
			side_s2.mid_y <= midy_s1;

			sqx_s3 <= SQ_W'(side_s2.ax) * SQ_W'(side_s2.ax);
			sqy_s3 <= SQ_W'(side_s2.ay) * SQ_W'(side_s2.ay);
			side_s3 <= side_s2;

			n_s4 <= sqx_s3 + sqy_s3;
			side_s4 <= side_s3;
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SQ_W-1:0]   n_in;
		side_t             side_in;
		logic [REM_W+1:0]  cur, trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign n_in = n_s4;
			assign side_in = side_s4;
		end else begin : g_next
			assign rem_in = sqrem_s[k-1];
			assign root_in = root_s[k-1];
			assign n_in = sqn_s[k-1];
			assign side_in = sqside_s[k-1];
		end

		assign cur = {rem_in, n_in[SQ_W-1-2*k -: 2]};
		assign trial = (REM_W+2)'({root_in, 2'b01});

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					sqrem_s[k] <= REM_W'(cur - trial);
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					sqrem_s[k] <= REM_W'(cur);
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				sqn_s[k] <= n_in;
				sqside_s[k] <= side_in;
			end
		end
	end

	for (genvar j = 0; j < NDIV; j++) begin : g_div
		logic [DREM_W-1:0] rx, ry;
		logic [QUO_W-1:0]  qx_in, qy_in;
		logic [ROOT_W-1:0] l_in;
		side_t             side_in;
		logic              bx, by;

		if (j == 0) begin : g_first
			assign rx = DREM_W'(sqside_s[NSQ-1].ax);
			assign ry = DREM_W'(sqside_s[NSQ-1].ay);
			assign qx_in = '0;
			assign qy_in = '0;
			assign l_in = root_s[NSQ-1];
			assign side_in = sqside_s[NSQ-1];
		end else begin : g_next
			assign rx = {remx_s[j-1][DREM_W-2:0], 1'b0};
			assign ry = {remy_s[j-1][DREM_W-2:0], 1'b0};
			assign qx_in = qx_s[j-1];
			assign qy_in = qy_s[j-1];
			assign l_in = len_s[j-1];
			assign side_in = dside_s[j-1];
		end

		assign bx = rx >= DREM_W'(l_in);
		assign by = ry >= DREM_W'(l_in);

		always_ff @(posedge clk) begin
			if (en) begin
				remx_s[j] <= bx ? rx - DREM_W'(l_in) : rx;
				remy_s[j] <= by ? ry - DREM_W'(l_in) : ry;
				qx_s[j] <= {qx_in[QUO_W-2:0], bx};
				qy_s[j] <= {qy_in[QUO_W-2:0], by};
				len_s[j] <= l_in;
				dside_s[j] <= side_in;
			end
		end
	end

	logic [ROOT_W-1:0] lf;
	side_t             sf;
	logic              degen;
	logic [NORM_W-1:0] mx, my;

	assign lf = len_s[NDIV-1];
	assign sf = dside_s[NDIV-1];
	assign degen = (lf == '0);
	assign mx = NORM_W'(qx_s[NDIV-1])
		+ NORM_W'({remx_s[NDIV-1], 1'b0} >= (DREM_W+1)'(lf));
	assign my = NORM_W'(qy_s[NDIV-1])
		+ NORM_W'({remy_s[NDIV-1], 1'b0} >= (DREM_W+1)'(lf));

	always_ff @(posedge clk) begin
		if (en) begin
			out_edge.normal_x <= degen ? '0 : (sf.sgn_x ? -mx : mx);
			out_edge.normal_y <= degen ? '0 : (sf.sgn_y ? -my : my);
			out_edge.edge_length <= LEN_W'(lf);
			out_edge.mid_x <= sf.mid_x;
			out_edge.mid_y <= sf.mid_y;
			out_edge.degenerate <= degen;
		end
	end

endmodule

// File: tb/edge_normal_length_midpoint_core_tb.sv
// Self-checking testbench for the edge normal, length and midpoint pipeline.
module edge_normal_length_midpoint_core_tb;
	import enlm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] normal_x;
		logic [31:0] normal_y;
		logic [32:0] edge_length;
		logic [31:0] mid_x;
		logic [31:0] mid_y;
		logic        degenerate;
	} edge_res_t;

	typedef struct {
		logic [31:0] sx;
		logic [31:0] sy;
		logic [31:0] ex;
		logic [31:0] ey;
		bit          typed;
		edge_res_t   res;
	} edge_row_t;

	logic clk;
	logic arst_n;
	enlm_in_if in_edge ();
	enlm_out_if out_edge ();

	edge_normal_length_midpoint_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_edge(in_edge.sink),
		.out_edge(out_edge.source)
	);

	edge_res_t pending_geometry[$];
	int mismatches;
	bit drive_done;
	edge_row_t rows[$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [63:0] root_floor(logic [65:0] n);
		logic [63:0] r;
		logic [63:0] c;
		r = '0;
		for (int b = 32; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({2'b0, c} * {2'b0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [31:0] unit_component(logic [32:0] mag, logic [32:0] len,
			logic neg);
		logic [65:0] num;
		logic [65:0] q;
		logic [65:0] rem;
		num = {33'd0, mag} << NORM_FRAC;
		q = num / len;
		rem = num % len;
		if (rem >= len - rem)
			q = q + 1;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic edge_res_t edge_geometry(logic [31:0] x0, logic [31:0] y0,
			logic [31:0] x1, logic [31:0] y1);
		logic signed [33:0] sxv;
		logic signed [33:0] syv;
		logic signed [33:0] sum;
		logic [32:0] ax;
		logic [32:0] ay;
		logic [63:0] len;
		edge_res_t r;
		sxv = $signed({{2{y1[31]}}, y1}) - $signed({{2{y0[31]}}, y0});
		syv = $signed({{2{x0[31]}}, x0}) - $signed({{2{x1[31]}}, x1});
		ax = sxv[33] ? 33'(-sxv) : sxv[32:0];
		ay = syv[33] ? 33'(-syv) : syv[32:0];
		len = root_floor({33'd0, ax} * {33'd0, ax} + {33'd0, ay} * {33'd0, ay});
		r.edge_length = len[32:0];
		r.degenerate = (len == 0);
		r.normal_x = r.degenerate ? '0 : unit_component(ax, len[32:0], sxv[33]);
		r.normal_y = r.degenerate ? '0 : unit_component(ay, len[32:0], syv[33]);
		sum = $signed({{2{x0[31]}}, x0}) + $signed({{2{x1[31]}}, x1});
		r.mid_x = sum[32:1];
		sum = $signed({{2{y0[31]}}, y0}) + $signed({{2{y1[31]}}, y1});
		r.mid_y = sum[32:1];
		return r;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000 + $urandom_range(0, 3);
			1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			2: return $urandom_range(0, 8) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_row(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
			logic [31:0] ey, bit typed, edge_res_t res);
		edge_row_t r;
		r.sx = sx;
		r.sy = sy;
		r.ex = ex;
		r.ey = ey;
		r.typed = typed;
		r.res = res;
		rows.push_back(r);
	endtask

	task automatic send_edge(edge_row_t r);
		int idle;
		idle = $urandom_range(0, 4);
		if (idle > 0) begin
			in_edge.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		in_edge.valid <= 1'b1;
		in_edge.start_x <= r.sx;
		in_edge.start_y <= r.sy;
		in_edge.end_x <= r.ex;
		in_edge.end_y <= r.ey;
		pending_geometry.push_back(r.typed ? r.res : edge_geometry(r.sx, r.sy, r.ex, r.ey));
		@(posedge clk);
		while (!in_edge.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		edge_row_t r;
		bit quiet;
		in_edge.valid = 1'b0;
		in_edge.start_x = '0;
		in_edge.start_y = '0;
		in_edge.end_x = '0;
		in_edge.end_y = '0;
		drive_done = 1'b0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Coincident points give a zero normal and raise the degenerate flag.
		add_row(32'd5, 32'd7, 32'd5, 32'd7, 1, '{0, 0, 0, 5, 7, 1});
		add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
			'{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1});
		add_row(0, 0, 0, 32'h0001_0000, 1, '{32'h4000_0000, 0, 33'h1_0000, 0, 32'h8000, 0});
		add_row(0, 0, 32'h0001_0000, 0, 1, '{0, 32'hC000_0000, 33'h1_0000, 32'h8000, 0, 0});
		add_row(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 1,
			'{0, 32'hC000_0000, 33'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0});
		add_row(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 1,
			'{32'hC000_0000, 0, 33'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0});
		add_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, '0);
		add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002, 0, '0);
		add_row(32'd1, 32'd0, 32'd0, 32'd1, 0, '0);
		add_row(32'd0, 32'd0, 32'd3, 32'd4, 0, '0);
		add_row(32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 0, '0);
		foreach (rows[i])
			send_edge(rows[i]);

		for (int i = 0; i < 450; i++) begin
			quiet = ($urandom_range(0, 19) == 0);
			r.sx = rand_coord();
			r.sy = rand_coord();
			r.ex = quiet ? r.sx : rand_coord();
			r.ey = quiet ? r.sy : rand_coord();
			if (!quiet && $urandom_range(0, 3) == 0) begin
				r.ex = r.sx + $urandom_range(0, 6) - 3;
				r.ey = r.sy + $urandom_range(0, 6) - 3;
			end
			r.typed = 0;
			send_edge(r);
		end
		in_edge.valid <= 1'b0;
		drive_done = 1'b1;
	end

	initial begin
		out_edge.ready = 1'b0;
		@(negedge clk);
		forever begin
			int idle;
			idle = $urandom_range(0, 4);
			if (idle > 0) begin
				out_edge.ready <= 1'b0;
				repeat (idle) @(negedge clk);
			end
			out_edge.ready <= 1'b1;
			@(posedge clk);
			while (!out_edge.valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		edge_res_t got;
		edge_res_t want;
		if (arst_n && out_edge.valid && out_edge.ready) begin
			got = '{out_edge.normal_x, out_edge.normal_y, out_edge.edge_length,
				out_edge.mid_x, out_edge.mid_y, out_edge.degenerate};
			if (pending_geometry.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected word: %p", got);
			end else begin
				want = pending_geometry.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	initial begin
		mismatches = 0;
		wait (drive_done);
		while (pending_geometry.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: filelist.f
rtl/enlm_pkg.sv
rtl/enlm_in_if.sv
rtl/enlm_out_if.sv
rtl/edge_normal_length_midpoint_core.sv
tb/edge_normal_length_midpoint_core_tb.sv
